FILE: hdl/mera_pkg.sv
package mera_pkg;

   localparam int AXIS_W      = 8;
   localparam int CLAMP_W     = 12;
   localparam int COORD_W     = 9;
   localparam int POS_W       = 10;
   localparam int SQ_W        = 16;
   localparam int STEP_W      = 26;
   localparam int DEC_W       = 40;
   localparam int MUL_W       = 22;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int VERTICES    = 4;

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef struct packed {
      logic              start;
      logic [AXIS_W-1:0] axis_a;
      logic [AXIS_W-1:0] axis_b;
   } cmd_type;

endpackage

FILE: hdl/mera_front.sv
module mera_front #(
   parameter int AXIS_MAX = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_type,
   input  logic [mera_pkg::AXIS_W-1:0]         req_semi_axis_a,
   input  logic [mera_pkg::AXIS_W-1:0]         req_semi_axis_b,
   output mera_pkg::cmd_type                   cmd,
   output logic                                cmd_valid,
   input  logic                                cmd_pop
);

   localparam int PTR_W = $clog2(mera_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(mera_pkg::QUEUE_DEPTH + 1);
   localparam logic [mera_pkg::CLAMP_W-1:0] AXIS_LIMIT = mera_pkg::CLAMP_W'(AXIS_MAX);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(mera_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(mera_pkg::QUEUE_DEPTH - 1);

   mera_pkg::cmd_type entries_ff [mera_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   mera_pkg::cmd_type cmd_in;
   logic              push_ok;
   logic              pop_ok;

   // clamp axes and classify the request
   always_comb begin
      cmd_in.start  = (req_type == mera_pkg::REQ_START);
      cmd_in.axis_a = (mera_pkg::CLAMP_W'(req_semi_axis_a) > AXIS_LIMIT) ?
                      AXIS_LIMIT[mera_pkg::AXIS_W-1:0] : req_semi_axis_a;
      cmd_in.axis_b = (mera_pkg::CLAMP_W'(req_semi_axis_b) > AXIS_LIMIT) ?
                      AXIS_LIMIT[mera_pkg::AXIS_W-1:0] : req_semi_axis_b;
   end

   assign full      = (count_ff == DEPTH_CNT);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entries_ff[rd_ptr_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push_ok, pop_ok})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: hdl/mera_back.sv
module mera_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mera_pkg::cmd_type                    cmd,
   input  logic                                 cmd_valid,
   output logic                                 cmd_pop,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [mera_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [mera_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic                                 rsp_last_of_point,
   output logic                                 rsp_final_point
);

   localparam int AW = mera_pkg::AXIS_W;
   localparam int CW = mera_pkg::COORD_W;
   localparam int PW = mera_pkg::POS_W;
   localparam int SW = mera_pkg::SQ_W;
   localparam int TW = mera_pkg::STEP_W;
   localparam int DW = mera_pkg::DEC_W;
   localparam int MW = mera_pkg::MUL_W;
   localparam int RW = mera_pkg::PROD_W;
   localparam int KW = $clog2(mera_pkg::VERTICES);
   localparam logic [KW-1:0] LAST_K = KW'(mera_pkg::VERTICES - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_A2, ST_B2, ST_A2B, ST_INIT, ST_STEP, ST_SETTLE,
      ST_T2, ST_U2, ST_BT, ST_AU, ST_AB, ST_R2, ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [AW-1:0]           a_ff;
   logic [AW-1:0]           b_ff;
   logic [SW-1:0]           a2_ff;
   logic [SW-1:0]           b2_ff;
   logic [PW-1:0]           pos_x_ff;
   logic signed [PW-1:0]    pos_y_ff;
   logic signed [TW-1:0]    dx_ff;
   logic signed [TW-1:0]    dy_ff;
   logic signed [DW-1:0]    dec_ff;
   logic                    region_two_ff;
   logic                    active_ff;
   logic                    after_load_ff;
   logic                    fin_ff;
   logic [PW-1:0]           emit_x_ff;
   logic signed [PW-1:0]    emit_y_ff;
   logic [MW-1:0]           tt_ff;
   logic [MW-1:0]           uu_ff;
   logic [RW-1:0]           acc_ff;
   logic [RW-1:0]           prod_ff;
   logic [KW-1:0]           k_ff;
   logic                    out_valid_ff;
   logic signed [CW-1:0]    out_x_ff;
   logic signed [CW-1:0]    out_y_ff;
   logic                    out_last_ff;
   logic                    out_fin_ff;

   logic [MW-1:0]           mul_a;
   logic [MW-1:0]           mul_b;
   logic [PW:0]             t_val;
   logic signed [PW:0]      u_val;
   logic [PW:0]             u_abs;
   logic signed [TW-1:0]    dx_n;
   logic signed [TW-1:0]    dy_n;
   logic signed [DW-1:0]    dx_e;
   logic signed [DW-1:0]    dy_e;
   logic signed [DW-1:0]    a2_e;
   logic signed [DW-1:0]    b2_e;
   logic [PW-1:0]           step_x;
   logic signed [PW-1:0]    step_y;
   logic signed [TW-1:0]    step_dx;
   logic signed [TW-1:0]    step_dy;
   logic signed [DW-1:0]    step_dec;
   logic                    go_region_two;
   logic                    settle_act;
   logic [CW-1:0]           vx;
   logic [CW-1:0]           vy;
   logic                    out_load;

   assign cmd_pop = cmd_valid && (state_ff == ST_IDLE);
   assign empty   = !out_valid_ff;
   assign rsp_vertex_x      = out_x_ff;
   assign rsp_vertex_y      = out_y_ff;
   assign rsp_last_of_point = out_last_ff;
   assign rsp_final_point   = out_fin_ff;

   // region two seed terms
   assign t_val = {pos_x_ff, 1'b1};
   assign u_val = $signed({pos_y_ff[PW-1], pos_y_ff}) - (PW+1)'(1);
   assign u_abs = u_val[PW] ? (PW+1)'(-u_val) : u_val;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_A2:   begin mul_a = MW'(a_ff);   mul_b = MW'(a_ff);  end
         ST_B2:   begin mul_a = MW'(b_ff);   mul_b = MW'(b_ff);  end
         ST_A2B:  begin mul_a = MW'(a2_ff);  mul_b = MW'(b_ff);  end
         ST_T2:   begin mul_a = MW'(t_val);  mul_b = MW'(t_val); end
         ST_U2:   begin mul_a = MW'(u_abs);  mul_b = MW'(u_abs); end
         ST_BT:   begin mul_a = MW'(b2_ff);  mul_b = tt_ff;      end
         ST_AU:   begin mul_a = MW'(a2_ff);  mul_b = uu_ff;      end
         ST_AB:   begin mul_a = MW'(a2_ff);  mul_b = MW'(b2_ff); end
         default: begin mul_a = '0;          mul_b = '0;         end
      endcase
   end

   // one midpoint step
   always_comb begin
      dx_n = dx_ff + TW'({b2_ff, 1'b0});
      dy_n = dy_ff - TW'({a2_ff, 1'b0});
      dx_e = DW'(dx_n);
      dy_e = DW'(dy_n);
      a2_e = $signed(DW'(a2_ff));
      b2_e = $signed(DW'(b2_ff));
      step_x   = pos_x_ff;
      step_y   = pos_y_ff;
      step_dx  = dx_ff;
      step_dy  = dy_ff;
      step_dec = dec_ff;
      if (!region_two_ff) begin
         step_x  = pos_x_ff + 1'b1;
         step_dx = dx_n;
         if (dec_ff[DW-1]) begin
            step_dec = dec_ff + ((dx_e + b2_e) <<< 2);
         end else begin
            step_y   = pos_y_ff - PW'(1);
            step_dy  = dy_n;
            step_dec = dec_ff + ((dx_e - dy_e + b2_e) <<< 2);
         end
      end else begin
         step_y  = pos_y_ff - PW'(1);
         step_dy = dy_n;
         if (dec_ff > 0) begin
            step_dec = dec_ff + ((a2_e - dy_e) <<< 2);
         end else begin
            step_x   = pos_x_ff + 1'b1;
            step_dx  = dx_n;
            step_dec = dec_ff + ((dx_e - dy_e + a2_e) <<< 2);
         end
      end
   end

   assign go_region_two = !region_two_ff && !(dx_ff < dy_ff);
   assign settle_act    = region_two_ff ? !pos_y_ff[PW-1] : 1'b1;

   assign vx = k_ff[0] ? CW'(0) - emit_x_ff[CW-1:0] : emit_x_ff[CW-1:0];
   assign vy = k_ff[1] ? CW'(0) - emit_y_ff[CW-1:0] : emit_y_ff[CW-1:0];
   assign out_load = !out_valid_ff || pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         after_load_ff <= 1'b0;
         region_two_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         k_ff          <= '0;
      end else begin
         prod_ff <= RW'(mul_a * mul_b);
         if (pop && out_valid_ff && (state_ff != ST_EMIT)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  if (cmd.start) begin
                     a_ff     <= cmd.axis_a;
                     b_ff     <= cmd.axis_b;
                     state_ff <= ST_A2;
                  end else if (active_ff) begin
                     emit_x_ff     <= pos_x_ff;
                     emit_y_ff     <= pos_y_ff;
                     after_load_ff <= 1'b0;
                     state_ff      <= ST_STEP;
                  end
               end
            end
            ST_A2: begin
               state_ff <= ST_B2;
            end
            ST_B2: begin
               a2_ff    <= prod_ff[SW-1:0];
               state_ff <= ST_A2B;
            end
            ST_A2B: begin
               b2_ff    <= prod_ff[SW-1:0];
               state_ff <= ST_INIT;
            end
            ST_INIT: begin
               pos_x_ff      <= '0;
               pos_y_ff      <= $signed(PW'(b_ff));
               dx_ff         <= '0;
               dy_ff         <= $signed(TW'({prod_ff, 1'b0}));
               dec_ff        <= $signed(DW'({b2_ff, 2'b00})) -
                                $signed(DW'({prod_ff, 2'b00})) +
                                $signed(DW'(a2_ff));
               region_two_ff <= 1'b0;
               after_load_ff <= 1'b1;
               state_ff      <= ST_SETTLE;
            end
            ST_STEP: begin
               pos_x_ff <= step_x;
               pos_y_ff <= step_y;
               dx_ff    <= step_dx;
               dy_ff    <= step_dy;
               dec_ff   <= step_dec;
               state_ff <= ST_SETTLE;
            end
            ST_SETTLE: begin
               if (go_region_two) begin
                  state_ff <= ST_T2;
               end else begin
                  active_ff <= settle_act;
                  if (after_load_ff) begin
                     if (settle_act) begin
                        emit_x_ff     <= pos_x_ff;
                        emit_y_ff     <= pos_y_ff;
                        after_load_ff <= 1'b0;
                        state_ff      <= ST_STEP;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     fin_ff   <= !settle_act;
                     k_ff     <= '0;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_T2: begin
               state_ff <= ST_U2;
            end
            ST_U2: begin
               tt_ff    <= prod_ff[MW-1:0];
               state_ff <= ST_BT;
            end
            ST_BT: begin
               uu_ff    <= prod_ff[MW-1:0];
               state_ff <= ST_AU;
            end
            ST_AU: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_AB;
            end
            ST_AB: begin
               acc_ff   <= acc_ff + {prod_ff[RW-3:0], 2'b00};
               state_ff <= ST_R2;
            end
            ST_R2: begin
               dec_ff        <= $signed(DW'(acc_ff - {prod_ff[RW-3:0], 2'b00}));
               region_two_ff <= 1'b1;
               state_ff      <= ST_SETTLE;
            end
            ST_EMIT: begin
               if (out_load) begin
                  out_valid_ff <= 1'b1;
                  out_x_ff     <= $signed(vx);
                  out_y_ff     <= $signed(vy);
                  out_last_ff  <= (k_ff == LAST_K);
                  out_fin_ff   <= fin_ff;
                  k_ff         <= k_ff + 1'b1;
                  if (k_ff == LAST_K) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: hdl/midpoint_ellipse_rasterizer_unit.sv
// Midpoint ellipse rasterizer. A start request (req_type 0) loads the semi-axes, clamped to
// AXIS_MAX, and yields the point (0,b); each advance request (req_type 1) yields the next
// point, and an advance with no ellipse in progress yields nothing. Every point comes out as
// four vertices (x,y), (-x,y), (x,-y), (-x,-y); the fourth carries last_of_point and all four
// of the closing point carry final_point. Requests wait in a two-entry queue in front of a
// sequencer that owns one shared multiplier and a one-entry result register. An advance
// steps the position (ST_STEP, then ST_SETTLE) and then emits the four vertices; a start first
// runs multiplies for a*a, b*b and a*a*b, and the change from region one to region two runs
// multiplies for the new decision value. Stalls on pop hold back the vertex output.
module midpoint_ellipse_rasterizer_unit #(
   parameter int AXIS_MAX = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_type,
   input  logic [mera_pkg::AXIS_W-1:0]          req_semi_axis_a,
   input  logic [mera_pkg::AXIS_W-1:0]          req_semi_axis_b,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [mera_pkg::COORD_W-1:0]  rsp_vertex_x,
   output logic signed [mera_pkg::COORD_W-1:0]  rsp_vertex_y,
   output logic                                 rsp_last_of_point,
   output logic                                 rsp_final_point
);

   mera_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;

   mera_front #(
      .AXIS_MAX (AXIS_MAX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_semi_axis_a (req_semi_axis_a),
      .req_semi_axis_b (req_semi_axis_b),
      .cmd             (cmd),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop)
   );

   mera_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_last_of_point (rsp_last_of_point),
      .rsp_final_point   (rsp_final_point)
   );

endmodule

FILE: hdl/mera_checker.sv
module mera_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 full,
   input logic                                 empty,
   input logic                                 pop,
   input logic signed [mera_pkg::COORD_W-1:0]  rsp_vertex_x,
   input logic signed [mera_pkg::COORD_W-1:0]  rsp_vertex_y,
   input logic                                 rsp_last_of_point,
   input logic                                 rsp_final_point
);

   // nothing queued or waiting right after reset
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not clear after reset");

   // a point's four vertices leave back to back
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_point) |=> !empty)
      else $error("gap inside a point");

   // final flag is the same on all vertices of a point
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_point) |=> rsp_final_point == $past(rsp_final_point))
      else $error("final flag changed inside a point");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_vertex_x) && $stable(rsp_vertex_y)
                           && $stable(rsp_last_of_point) && $stable(rsp_final_point))
      else $error("stalled result changed");

endmodule

bind midpoint_ellipse_rasterizer_unit mera_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_vertex_x      (rsp_vertex_x),
   .rsp_vertex_y      (rsp_vertex_y),
   .rsp_last_of_point (rsp_last_of_point),
   .rsp_final_point   (rsp_final_point)
);

FILE: tb/midpoint_ellipse_rasterizer_unit_tb.sv
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit_tb;

   localparam int AXIS_MAX    = 255;
   localparam int ITEMS       = 430;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_AT    = 220;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      logic                        kind;
      logic [mera_pkg::AXIS_W-1:0] a;
      logic [mera_pkg::AXIS_W-1:0] b;
      int unsigned                 gap;
      bit                          drain;
   } ellipse_request_type;

   typedef struct {
      logic signed [mera_pkg::COORD_W-1:0] vx;
      logic signed [mera_pkg::COORD_W-1:0] vy;
      logic                                last;
      logic                                fin;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic req_type = mera_pkg::REQ_START;
   logic [mera_pkg::AXIS_W-1:0] req_semi_axis_a = '0;
   logic [mera_pkg::AXIS_W-1:0] req_semi_axis_b = '0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   logic signed [mera_pkg::COORD_W-1:0] rsp_vertex_x;
   logic signed [mera_pkg::COORD_W-1:0] rsp_vertex_y;
   logic rsp_last_of_point;
   logic rsp_final_point;

   ellipse_request_type pending_requests[$];
   vertex_type          expected_vertices[$];
   ellipse_request_type cur_req;

   // predictor state
   logic [mera_pkg::AXIS_W-1:0]  cur_a = '0;
   logic [mera_pkg::AXIS_W-1:0]  cur_b = '0;
   logic [mera_pkg::COORD_W-1:0] px = '0;
   logic signed [9:0]            py = -10'sd1;
   logic signed [25:0]           dx_acc = '0;
   logic signed [25:0]           dy_acc = '0;
   logic signed [39:0]           dval = '0;
   bit                           region2 = 1'b0;
   bit                           pt_live = 1'b0;

   int unsigned n_queued = 0;
   int unsigned gap_cnt = 0;
   int unsigned rx_wait = 0;
   int unsigned rx_hold = 0;
   bit          rx_calm = 1'b0;
   bit          tx_calm = 1'b0;
   bit          drain_placed = 1'b0;
   int unsigned fails = 0;
   int unsigned starts_sent = 0;
   int unsigned advances_sent = 0;
   int unsigned idle_advances = 0;
   int unsigned vertices_checked = 0;

   midpoint_ellipse_rasterizer_unit #(
      .AXIS_MAX(AXIS_MAX)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_semi_axis_a  (req_semi_axis_a),
      .req_semi_axis_b  (req_semi_axis_b),
      .empty            (empty),
      .pop              (pop),
      .rsp_vertex_x     (rsp_vertex_x),
      .rsp_vertex_y     (rsp_vertex_y),
      .rsp_last_of_point(rsp_last_of_point),
      .rsp_final_point  (rsp_final_point)
   );

   always #1 clock = ~clock;

   function automatic void enter_region_two();
      longint a2, b2, t, u;
      a2 = longint'(cur_a) * longint'(cur_a);
      b2 = longint'(cur_b) * longint'(cur_b);
      t = 2 * longint'(px) + 1;
      u = longint'(py) - 1;
      dval = b2 * t * t + 4 * a2 * u * u - 4 * a2 * b2;
      region2 = 1'b1;
   endfunction

   function automatic bit settle_point();
      if (!region2) begin
         if (dx_acc < dy_acc) return 1'b1;
         enter_region_two();
      end
      return py >= 0;
   endfunction

   function automatic bit step_point();
      longint a2, b2, dx, dy, d;
      a2 = longint'(cur_a) * longint'(cur_a);
      b2 = longint'(cur_b) * longint'(cur_b);
      dx = dx_acc;
      dy = dy_acc;
      d = dval;
      if (!region2) begin
         px = px + 1'b1;
         dx = dx + 2 * b2;
         if (d < 0) begin
            d = d + 4 * (dx + b2);
         end else begin
            py = py - 1'b1;
            dy = dy - 2 * a2;
            d = d + 4 * (dx - dy + b2);
         end
      end else begin
         py = py - 1'b1;
         dy = dy - 2 * a2;
         if (d > 0) begin
            d = d + 4 * (a2 - dy);
         end else begin
            px = px + 1'b1;
            dx = dx + 2 * b2;
            d = d + 4 * (dx - dy + a2);
         end
      end
      dx_acc = dx;
      dy_acc = dy;
      dval = d;
      return settle_point();
   endfunction

   function automatic void push_vertex(longint x, longint y, logic last, logic fin);
      vertex_type v;
      v.vx = mera_pkg::COORD_W'(x);
      v.vy = mera_pkg::COORD_W'(y);
      v.last = last;
      v.fin = fin;
      expected_vertices.push_back(v);
   endfunction

   function automatic void predict_request(ellipse_request_type r);
      longint a, b, x0, y0;
      logic closing;
      if (r.kind == mera_pkg::REQ_START) begin
         starts_sent++;
         cur_a = (r.a > AXIS_MAX) ? mera_pkg::AXIS_W'(AXIS_MAX) : r.a;
         cur_b = (r.b > AXIS_MAX) ? mera_pkg::AXIS_W'(AXIS_MAX) : r.b;
         a = cur_a;
         b = cur_b;
         px = '0;
         py = cur_b;
         dx_acc = '0;
         dy_acc = 2 * a * a * b;
         dval = 4 * b * b - 4 * a * a * b + a * a;
         region2 = 1'b0;
         pt_live = settle_point();
      end else begin
         advances_sent++;
      end
      if (!pt_live) begin
         idle_advances++;
         return;
      end
      x0 = px;
      y0 = py;
      pt_live = step_point();
      closing = !pt_live;
      push_vertex(x0, y0, 1'b0, closing);
      push_vertex(-x0, y0, 1'b0, closing);
      push_vertex(x0, -y0, 1'b0, closing);
      push_vertex(-x0, -y0, 1'b1, closing);
   endfunction

   function automatic void add_request(logic kind, logic [mera_pkg::AXIS_W-1:0] a,
                                       logic [mera_pkg::AXIS_W-1:0] b, bit drain);
      ellipse_request_type r;
      r.kind = kind;
      r.a = a;
      r.b = b;
      r.gap = tx_calm ? 0 : $urandom_range(0, 13);
      r.drain = drain;
      pending_requests.push_back(r);
      n_queued++;
      if (n_queued % 40 == 0) tx_calm = !tx_calm;
   endfunction

   // request driver
   always @(posedge clock) begin
      bit accepted;
      bit next_push;
      if (reset) begin
         push <= 1'b0;
         gap_cnt = 0;
      end else begin
         accepted = push && !full;
         next_push = push;
         if (accepted) predict_request(cur_req);
         if (!push || accepted) begin
            next_push = 1'b0;
            if (pending_requests.size() != 0) begin
               if (gap_cnt < pending_requests[0].gap) begin
                  gap_cnt++;
               end else if (!(pending_requests[0].drain && expected_vertices.size() != 0)) begin
                  cur_req = pending_requests.pop_front();
                  gap_cnt = 0;
                  next_push = 1'b1;
                  req_type <= cur_req.kind;
                  req_semi_axis_a <= cur_req.a;
                  req_semi_axis_b <= cur_req.b;
               end
            end
         end
         push <= next_push;
      end
   end

   // vertex monitor
   always @(posedge clock) begin
      vertex_type v;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_vertices.size() == 0) begin
               $error("vertex (%0d,%0d) with none expected", rsp_vertex_x, rsp_vertex_y);
               fails++;
            end else begin
               v = expected_vertices.pop_front();
               if (rsp_vertex_x !== v.vx) begin
                  $error("vertex_x expected %0d got %0d", v.vx, rsp_vertex_x);
                  fails++;
               end
               if (rsp_vertex_y !== v.vy) begin
                  $error("vertex_y expected %0d got %0d", v.vy, rsp_vertex_y);
                  fails++;
               end
               if (rsp_last_of_point !== v.last) begin
                  $error("last_of_point expected %0b got %0b", v.last, rsp_last_of_point);
                  fails++;
               end
               if (rsp_final_point !== v.fin) begin
                  $error("final_point expected %0b got %0b", v.fin, rsp_final_point);
                  fails++;
               end
            end
            vertices_checked++;
            rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
            if (vertices_checked == HOLD_AT) rx_hold = HOLD_CYCLES;
            if (vertices_checked % 60 == 0) rx_calm = !rx_calm;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      logic [mera_pkg::AXIS_W-1:0] ax, bx;
      int unsigned runs;
      bit drain;

      // advances with nothing pending, then a tiny ellipse run past its end
      add_request(mera_pkg::REQ_ADVANCE, 8'hff, 8'h00, 1'b0);
      add_request(mera_pkg::REQ_ADVANCE, 8'h00, 8'hff, 1'b0);
      add_request(mera_pkg::REQ_START, 8'd3, 8'd2, 1'b0);
      repeat (8) add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);
      // largest axes, aborted by the next start
      add_request(mera_pkg::REQ_START, 8'd255, 8'd255, 1'b0);
      repeat (2) add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);
      add_request(mera_pkg::REQ_START, 8'd255, 8'd1, 1'b0);
      add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);
      add_request(mera_pkg::REQ_START, 8'd1, 8'd255, 1'b0);
      add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);
      // zero axes
      add_request(mera_pkg::REQ_START, 8'd0, 8'd2, 1'b0);
      repeat (4) add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);
      add_request(mera_pkg::REQ_START, 8'd2, 8'd0, 1'b0);
      add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);
      add_request(mera_pkg::REQ_START, 8'd0, 8'd0, 1'b0);
      add_request(mera_pkg::REQ_ADVANCE, 8'd0, 8'd0, 1'b0);

      while (n_queued < ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            add_request(mera_pkg::REQ_ADVANCE, 8'($urandom), 8'($urandom), 1'b0);
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               ax = 8'($urandom);
               bx = 8'($urandom);
               runs = $urandom_range(0, 10);
            end else begin
               ax = 8'($urandom_range(0, 15));
               bx = 8'($urandom_range(0, 15));
               runs = $urandom_range(0, 45);
            end
            drain = (n_queued >= DRAIN_AT) && !drain_placed;
            if (drain) drain_placed = 1'b1;
            add_request(mera_pkg::REQ_START, ax, bx, drain);
            repeat (runs)
               add_request(mera_pkg::REQ_ADVANCE, 8'($urandom), 8'($urandom), 1'b0);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || push || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d starts and %0d advances (%0d with no point pending)",
               starts_sent, advances_sent, idle_advances);
      $display("checked %0d vertices under random gaps and a long output stall",
               vertices_checked);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: midpoint_ellipse_rasterizer_unit.f
hdl/mera_pkg.sv
hdl/mera_front.sv
hdl/mera_back.sv
hdl/midpoint_ellipse_rasterizer_unit.sv
hdl/mera_checker.sv
tb/midpoint_ellipse_rasterizer_unit_tb.sv
